### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files, included by laop_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check on the rising clock edge, disabled in reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Concurrent check on the rising clock edge, also checked in reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hw/rtl/laop_pkg.sv
// Package: types and constants of the lifetime aware offset placer
package laop_pkg;
   localparam int FREE_ENTRIES = 32;
   localparam int IDX_W = $clog2(FREE_ENTRIES);
   localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

   typedef struct packed {
      logic        starts_bucket;
      logic [40:0] request_size;
      logic [4:0]  align_log2;
      logic [15:0] first_use_pass;
      logic [15:0] last_use_pass;
   } req_type;

   typedef struct packed {
      logic [47:0] placed_offset;
      logic        reused_range;
      logic [47:0] bucket_extent;
      logic [4:0]  largest_align_log2;
      logic        list_overflow;
   } rsp_type;

   typedef struct packed {
      logic [47:0] offset;
      logic [40:0] size;
      logic [15:0] free_after;
   } entry_type;

   // control from the sequencer to the ring: shift goes to every cell, drop and load steer the tail feed
   typedef struct packed {
      logic shift;        // rotate the ring by one
      logic drop;         // tail feed takes cell 1, closing up over the erased entry
      logic load;         // tail feed takes the new entry
   } ring_ctl_type;

   function automatic logic [47:0] align_up(input logic [47:0] v, input logic [4:0] e);
      logic [47:0] m;
      m = (48'd1 << e) - 48'd1;
      return (v + m) & ~m;
   endfunction
endpackage

### hw/rtl/laop_cell.sv
// One storage cell of the free range ring
module laop_cell
   import laop_pkg::*;
(
   input  logic         clock,
   input  logic         shift,
   input  entry_type    entry_i,
   output entry_type    entry_o
);
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift) entry_in = entry_i;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;
endmodule

### hw/rtl/laop_ctrl.sv
// Sequencer: scans the ring head once per entry and builds the result
module laop_ctrl
   import laop_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  entry_type    head,
   output entry_type    tail_new,
   output ring_ctl_type ctl
);
   `include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0, ST_SCAN = 2'd1, ST_EMIT = 2'd2, ST_PACK = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [47:0]      high_ff, high_in;
   logic [4:0]       maxe_ff, maxe_in;
   req_type          req_ff, req_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [40:0]      bsize_ff, bsize_in;
   logic [47:0]      boff_ff, boff_in;
   logic             rv_ff, rv_in;
   rsp_type          rsp_ff, rsp_in;

   logic [48:0] amask, cand;
   logic [49:0] cand_end, rng_end;
   logic        fits;
   logic [47:0] off_w, high_w;
   logic [CNT_W-1:0] cnt_after;

   // aligned candidate keeps its carry past 48 bits
   assign amask    = (49'd1 << req_ff.align_log2) - 49'd1;
   assign cand     = ({1'b0, head.offset} + amask) & ~amask;
   assign cand_end = {1'b0, cand} + {9'd0, req_ff.request_size};
   assign rng_end  = {2'b0, head.offset} + {9'd0, head.size};
   assign fits     = (head.free_after < req_ff.first_use_pass) && (cand_end <= rng_end)
                     && (!found_ff || head.size < bsize_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      high_in  = high_ff;
      maxe_in  = maxe_ff;
      req_in   = req_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bsize_in = bsize_ff;
      boff_in  = boff_ff;
      rv_in    = rv_ff;
      rsp_in   = rsp_ff;
      ctl      = '0;
      tail_new = '{offset: boff_ff, size: req_ff.request_size,
                   free_after: req_ff.last_use_pass};
      off_w    = align_up(high_ff, req_ff.align_log2);
      high_w   = off_w + {7'd0, req_ff.request_size};
      cnt_after = count_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               found_in = 1'b0;
               step_in  = '0;
               if (req_data.starts_bucket) begin
                  count_in = '0;
                  high_in  = '0;
                  maxe_in  = (req_data.align_log2 > 5'd0) ? req_data.align_log2 : 5'd0;
               end else if (req_data.align_log2 > maxe_ff) begin
                  maxe_in = req_data.align_log2;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // full rotation: every cell moves through the head once
            if (step_ff == CNT_W'(FREE_ENTRIES)) begin
               state_in = ST_EMIT;
            end else begin
               ctl.shift = 1'b1;
               if (step_ff < count_ff && fits) begin
                  found_in = 1'b1;
                  best_in  = step_ff[IDX_W-1:0];
                  bsize_in = head.size;
                  boff_in  = cand[47:0];
               end
               step_in = step_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!found_ff) begin
               boff_in = off_w;
               high_in = high_w;
            end
            step_in  = '0;
            state_in = ST_PACK;
         end
         ST_PACK: begin
            // rotate once more, closing up over the chosen entry and appending at the end
            cnt_after = found_ff ? count_ff - CNT_W'(1) : count_ff;
            if (step_ff == CNT_W'(FREE_ENTRIES)) begin
               if (!rv_ff || rsp_ready) begin
                  rv_in = 1'b1;
                  rsp_in.placed_offset      = boff_ff;
                  rsp_in.reused_range       = found_ff;
                  rsp_in.bucket_extent      = high_ff;
                  rsp_in.largest_align_log2 = maxe_ff;
                  rsp_in.list_overflow      = (cnt_after == CNT_W'(FREE_ENTRIES));
                  count_in = (cnt_after == CNT_W'(FREE_ENTRIES)) ? cnt_after
                             : cnt_after + CNT_W'(1);
                  state_in = ST_IDLE;
               end
            end else begin
               ctl.shift = 1'b1;
               if (found_ff && step_ff >= CNT_W'(best_ff))
                  ctl.drop = 1'b1;
               if (step_ff == cnt_after)
                  ctl.load = 1'b1;
               step_in = step_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         high_ff  <= '0;
         maxe_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         maxe_ff  <= maxe_in;
         rv_ff    <= rv_in;
      end
      step_ff  <= step_in;
      req_ff   <= req_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bsize_ff <= bsize_in;
      boff_ff  <= boff_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_cnt_bound, clock, reset, count_ff <= CNT_W'(FREE_ENTRIES),
               "free list count past depth")
   `ASSERT_CLK(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_ready,
               "request taken while busy")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_data),
               "result changed while stalled")
endmodule

### hw/rtl/laop_ring.sv
// Ring of cells holding the free ranges, with compaction at the head
module laop_ring
   import laop_pkg::*;
(
   input  logic         clock,
   input  ring_ctl_type ctl,
   input  entry_type    tail_new,
   output entry_type    head
);
   entry_type link [FREE_ENTRIES];
   entry_type feed;

   // link[0] is the head cell; data flows toward index 0 and wraps around
   for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_cell
      entry_type nin;
      if (g == FREE_ENTRIES - 1) begin : g_last
         assign nin = feed;
      end else begin : g_mid
         assign nin = link[g+1];
      end
      laop_cell u_cell (.clock(clock), .shift(ctl.shift), .entry_i(nin), .entry_o(link[g]));
   end

   assign feed = ctl.load ? tail_new : (ctl.drop ? link[1] : link[0]);
   assign head = link[0];
endmodule

### hw/rtl/lifetime_aware_offset_placer_top.sv
// Top level: lifetime aware best fit offset placer
// Usage:
//  req channel: one placement request per transfer (req_valid/req_ready, req_data).
//  rsp channel: one result per request (rsp_valid/rsp_ready, rsp_data).
//  The free range list lives in a ring of FREE_ENTRIES cells rotating through
//  a single compare unit at the head.
//  Order: a scan rotation of the ring (ST_SCAN), a placement step (ST_EMIT), then a
//  compaction rotation (ST_PACK); requests are handled one at a time.
//  Throughput is set by the two full rotations of the ring while results are not stalled.
//  Reset: empties the list, zeroes high mark and largest alignment; no clearing
//  pass is needed.
//  Stall: a result waits in the output register; the next request is taken
//  as soon as the previous one is finished.
//  starts_bucket clears the bucket state before the request is placed.
module lifetime_aware_offset_placer_top
   import laop_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   entry_type    head, tail_new;
   ring_ctl_type ctl;

   laop_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .head(head), .tail_new(tail_new), .ctl(ctl)
   );

   laop_ring u_ring (
      .clock(clock), .ctl(ctl), .tail_new(tail_new), .head(head)
   );
endmodule

### verif/tb_top.sv
// Testbench for the lifetime aware offset placer: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module tb_top;
   import laop_pkg::*;

   class placement_board;
      logic [47:0] rng_off[FREE_ENTRIES];
      logic [40:0] rng_size[FREE_ENTRIES];
      logic [15:0] rng_after[FREE_ENTRIES];
      int unsigned rng_count;
      logic [47:0] mark;
      logic [4:0] top_align;
      rsp_type pending[$];
      int errors;

      function new();
         rng_count = 0;
         mark = '0;
         top_align = '0;
         errors = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type res;
         logic [47:0] step_mask, cand, offset;
         logic [63:0] lim, need;
         bit found;
         int unsigned best;
         res = '0;
         found = 0;
         best = 0;
         offset = '0;
         if (r.starts_bucket) begin
            rng_count = 0;
            mark = '0;
            top_align = '0;
         end
         if (r.align_log2 > top_align) top_align = r.align_log2;
         step_mask = (48'd1 << r.align_log2) - 48'd1;
         for (int i = 0; i < rng_count; i++) begin
            if (rng_after[i] >= r.first_use_pass) continue;
            need = {16'd0, rng_off[i]} + {16'd0, step_mask};
            need = need & ~{16'd0, step_mask};
            lim = {16'd0, rng_off[i]} + {23'd0, rng_size[i]};
            if (need + {23'd0, r.request_size} <= lim &&
                (!found || rng_size[i] < rng_size[best])) begin
               found = 1;
               best = i;
               offset = need[47:0];
            end
         end
         if (found) begin
            for (int i = best; i + 1 < rng_count; i++) begin
               rng_off[i] = rng_off[i+1];
               rng_size[i] = rng_size[i+1];
               rng_after[i] = rng_after[i+1];
            end
            rng_count--;
         end else begin
            offset = (mark + step_mask) & ~step_mask;
            mark = offset + {7'd0, r.request_size};
         end
         if (rng_count < FREE_ENTRIES) begin
            rng_off[rng_count] = offset;
            rng_size[rng_count] = r.request_size;
            rng_after[rng_count] = r.last_use_pass;
            rng_count++;
         end else begin
            res.list_overflow = 1;
         end
         res.placed_offset = offset;
         res.reused_range = found;
         res.bucket_extent = mark;
         res.largest_align_log2 = top_align;
         pending.insert(pending.size(), res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type w;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.placed_offset !== w.placed_offset) begin
            $error("placed_offset exp %h got %h", w.placed_offset, got.placed_offset);
            errors++;
         end
         if (got.reused_range !== w.reused_range) begin
            $error("reused_range exp %h got %h", w.reused_range, got.reused_range);
            errors++;
         end
         if (got.bucket_extent !== w.bucket_extent) begin
            $error("bucket_extent exp %h got %h", w.bucket_extent, got.bucket_extent);
            errors++;
         end
         if (got.largest_align_log2 !== w.largest_align_log2) begin
            $error("largest_align_log2 exp %h got %h", w.largest_align_log2,
                   got.largest_align_log2);
            errors++;
         end
         if (got.list_overflow !== w.list_overflow) begin
            $error("list_overflow exp %h got %h", w.list_overflow, got.list_overflow);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   placement_board board = new();
   longint cycles = 0;
   bit stim_done = 0;
   logic [15:0] pass_now = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   lifetime_aware_offset_placer_top dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      if (cycles > 1000000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int m;
      m = int'((cycles / 500) % 3);
      if (m == 0) rsp_ready <= 1;
      else if (m == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 9) < 3);
   end

   task automatic send(req_type r);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic req_type mk(bit sb, logic [40:0] sz, logic [4:0] al,
                                  logic [15:0] f, logic [15:0] l);
      req_type r;
      r.starts_bucket = sb;
      r.request_size = sz;
      r.align_log2 = al;
      r.first_use_pass = f;
      r.last_use_pass = l;
      return r;
   endfunction

   function automatic logic [40:0] rand_size();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return 41'({$urandom, $urandom});
      if (k == 1) return 41'd0;
      if (k == 2) return 41'h100_0000_0000;
      return 41'($urandom_range(1, 4096));
   endfunction

   task automatic random_req(bit sb);
      logic [15:0] f, l;
      logic [4:0] al;
      if ($urandom_range(0, 15) == 0) begin
         f = 16'($urandom);
         l = 16'($urandom);
      end else begin
         if (!sb) pass_now = 16'(pass_now + $urandom_range(0, 2));
         else pass_now = 16'($urandom_range(0, 3));
         f = pass_now;
         l = 16'(pass_now + $urandom_range(0, 4));
      end
      al = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 8));
      send(mk(sb, rand_size(), al, f, l));
   endtask

   initial begin
      int burst;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(mk(0, 41'd100, 5'd0, 16'd0, 16'd0));
      send(mk(0, 41'd40, 5'd3, 16'd1, 16'd1));
      send(mk(0, 41'd50, 5'd4, 16'd2, 16'd5));
      send(mk(0, 41'd0, 5'd0, 16'd2, 16'd2));
      send(mk(1, 41'h1FF_FFFF_FFFF, 5'd31, 16'd0, 16'hFFFF));
      send(mk(0, 41'h1FF_FFFF_FFFF, 5'd16, 16'hFFFF, 16'hFFFF));
      send(mk(0, 41'h1FF_FFFF_FFFF, 5'd16, 16'hFFFF, 16'hFFFF));
      send(mk(0, 41'h1FF_FFFF_FFFF, 5'd16, 16'hFFFF, 16'hFFFF));
      send(mk(1, 41'd1, 5'd0, 16'hFFFF, 16'h0));
      send(mk(0, 41'd8, 5'd2, 16'h0, 16'hFFFF));
      // fill the list to force overflow
      send(mk(1, 41'd16, 5'd0, 16'd0, 16'd10));
      for (int i = 0; i < 34; i++) send(mk(0, 41'd16, 5'd0, 16'd1, 16'd10));
      send(mk(0, 41'd8, 5'd1, 16'd11, 16'd12));
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      @(posedge clock);
      // random, in buckets
      for (int n = 0; n < 1250;) begin
         burst = $urandom_range(1, 20);
         for (int j = 0; j < burst && n < 1250; j++, n++)
            random_req(($urandom_range(0, 39) == 0) || n == 0);
         if ($urandom_range(0, 2) != 0) gap();
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * FREE_ENTRIES + 20) @(posedge clock);
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
